@@ rtl/core/mftf_pkg.sv @@
// Package for the masked five-tuple filter table: sizes, codes and the queued command.
// No dependencies.
package mftf_pkg;
	localparam int MAX_ENTRIES = 8;
	localparam int IDX_W = 3;
	localparam int LINK_W = 4;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_ENTRIES);
	localparam int CNT_W = 4;
	localparam int QDEPTH = 2;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_MASK = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_CHECK = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_ZERO_SOCK = 3'd2;
	localparam logic [2:0] ST_NO_MATCH = 3'd3;
	localparam logic [2:0] ST_UNUSED = 3'd4;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] entry;
		logic [31:0] src_ip;
		logic [15:0] sport;
		logic [31:0] dst_ip;
		logic [15:0] dport;
		logic [7:0] protocol;
		logic [15:0] socket_id;
		logic [31:0] sip_mask;
		logic [15:0] sport_mask;
		logic [31:0] dip_mask;
		logic [15:0] dport_mask;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] entry_index;
		logic [15:0] matched_socket;
		logic [3:0] used_count;
	} res_t;
endpackage

@@ rtl/core/mftf_front.sv @@
// Front end: accepts commands and holds them in a short queue.
// Depends on mftf_pkg.
module mftf_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input mftf_pkg::cmd_t in_cmd,
	output logic q_valid,
	input logic q_pop,
	output mftf_pkg::cmd_t q_cmd
);
	mftf_pkg::cmd_t mem_q [mftf_pkg::QDEPTH];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'(mftf_pkg::QDEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

@@ rtl/core/mftf_back.sv @@
// Back end: filter table, free and priority lists, sequential check walk.
// Depends on mftf_pkg.
module mftf_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input mftf_pkg::cmd_t q_cmd,
	output logic out_valid,
	input logic out_stall,
	output mftf_pkg::res_t out_res
);
	localparam int N = mftf_pkg::MAX_ENTRIES;
	typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

	logic [31:0] k_sip_q [N];
	logic [31:0] k_dip_q [N];
	logic [15:0] k_sp_q [N];
	logic [15:0] k_dp_q [N];
	logic [31:0] m_sip_q [N];
	logic [31:0] m_dip_q [N];
	logic [15:0] m_sp_q [N];
	logic [15:0] m_dp_q [N];
	logic [7:0] k_pr_q [N];
	logic [15:0] sock_q [N];
	logic [N-1:0] used_q;
	logic [mftf_pkg::LINK_W-1:0] nxt_q [N];
	logic [mftf_pkg::LINK_W-1:0] prv_q [N];
	logic [mftf_pkg::LINK_W-1:0] head_q, free_q, cur_q;
	logic [mftf_pkg::CNT_W-1:0] used_cnt_q;
	logic [mftf_pkg::CNT_W-1:0] steps_q;
	state_t state_q;
	mftf_pkg::cmd_t cmd_q;

	logic [mftf_pkg::IDX_W-1:0] f, e, r, pe, ne;
	logic hit;

	assign f = cur_q[mftf_pkg::IDX_W-1:0];
	assign e = q_cmd.entry;
	assign r = free_q[mftf_pkg::IDX_W-1:0];
	assign pe = prv_q[e][mftf_pkg::IDX_W-1:0];
	assign ne = nxt_q[e][mftf_pkg::IDX_W-1:0];
	assign q_pop = (state_q == S_IDLE) && q_valid;

	// masked compare of the current walk entry
	assign hit = (k_pr_q[f] == cmd_q.protocol)
		&& ((k_sip_q[f] & m_sip_q[f]) == (cmd_q.src_ip & m_sip_q[f]))
		&& ((k_sp_q[f] & m_sp_q[f]) == (cmd_q.sport & m_sp_q[f]))
		&& ((k_dip_q[f] & m_dip_q[f]) == (cmd_q.dst_ip & m_dip_q[f]))
		&& ((k_dp_q[f] & m_dp_q[f]) == (cmd_q.dport & m_dp_q[f]))
		&& (sock_q[f] != 16'd0);

	// key and mask storage
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.mode == mftf_pkg::MODE_ADD && q_cmd.socket_id != 16'd0
				&& free_q != mftf_pkg::NIL) begin
			k_sip_q[r] <= q_cmd.src_ip;
			k_dip_q[r] <= q_cmd.dst_ip;
			k_sp_q[r] <= q_cmd.sport;
			k_dp_q[r] <= q_cmd.dport;
			k_pr_q[r] <= q_cmd.protocol;
			sock_q[r] <= q_cmd.socket_id;
			m_sip_q[r] <= 32'hffffffff;
			m_dip_q[r] <= 32'hffffffff;
			m_sp_q[r] <= 16'hffff;
			m_dp_q[r] <= 16'hffff;
		end
		if (q_pop && q_cmd.mode == mftf_pkg::MODE_MASK && used_q[e]) begin
			m_sip_q[e] <= q_cmd.sip_mask;
			m_sp_q[e] <= q_cmd.sport_mask;
			m_dip_q[e] <= q_cmd.dip_mask;
			m_dp_q[e] <= q_cmd.dport_mask;
		end
	end

	// control: lists, walk, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			for (int i = 0; i < N; i++) begin
				nxt_q[i] <= mftf_pkg::LINK_W'(i + 1);
				prv_q[i] <= mftf_pkg::NIL;
			end
			head_q <= mftf_pkg::NIL;
			free_q <= '0;
			used_cnt_q <= '0;
			cur_q <= mftf_pkg::NIL;
			steps_q <= '0;
			out_valid <= 1'b0;
			out_res <= '0;
			cmd_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						out_res <= '0;
						out_res.used_count <= used_cnt_q;
						state_q <= S_DONE;
						case (q_cmd.mode)
							mftf_pkg::MODE_ADD: begin
								if (q_cmd.socket_id == 16'd0) begin
									out_res.status <= mftf_pkg::ST_ZERO_SOCK;
								end else if (free_q == mftf_pkg::NIL) begin
									out_res.status <= mftf_pkg::ST_FULL;
								end else begin
									free_q <= nxt_q[r];
									if (nxt_q[r] != mftf_pkg::NIL)
										prv_q[nxt_q[r][mftf_pkg::IDX_W-1:0]] <= mftf_pkg::NIL;
									used_q[r] <= 1'b1;
									prv_q[r] <= mftf_pkg::NIL;
									nxt_q[r] <= head_q;
									if (head_q != mftf_pkg::NIL)
										prv_q[head_q[mftf_pkg::IDX_W-1:0]] <= free_q;
									head_q <= free_q;
									used_cnt_q <= used_cnt_q + mftf_pkg::CNT_W'(1);
									out_res.used_count <= used_cnt_q + mftf_pkg::CNT_W'(1);
									out_res.entry_index <= r;
								end
							end
							mftf_pkg::MODE_MASK: begin
								if (!used_q[e]) out_res.status <= mftf_pkg::ST_UNUSED;
							end
							mftf_pkg::MODE_REMOVE: begin
								if (!used_q[e]) begin
									out_res.status <= mftf_pkg::ST_UNUSED;
								end else begin
									if (head_q == {1'b0, e}) begin
										head_q <= nxt_q[e];
										if (nxt_q[e] != mftf_pkg::NIL)
											prv_q[ne] <= mftf_pkg::NIL;
									end else begin
										if (prv_q[e] != mftf_pkg::NIL) nxt_q[pe] <= nxt_q[e];
										if (nxt_q[e] != mftf_pkg::NIL) prv_q[ne] <= prv_q[e];
									end
									nxt_q[e] <= free_q;
									prv_q[e] <= mftf_pkg::NIL;
									if (free_q != mftf_pkg::NIL) prv_q[r] <= {1'b0, e};
									free_q <= {1'b0, e};
									used_q[e] <= 1'b0;
									if (used_cnt_q != '0) begin
										used_cnt_q <= used_cnt_q - mftf_pkg::CNT_W'(1);
										out_res.used_count <= used_cnt_q - mftf_pkg::CNT_W'(1);
									end
								end
							end
							default: begin
								cmd_q <= q_cmd;
								cur_q <= head_q;
								steps_q <= '0;
								state_q <= S_WALK;
							end
						endcase
					end
				end
				S_WALK: begin
					if (cur_q == mftf_pkg::NIL
							|| steps_q == mftf_pkg::CNT_W'(mftf_pkg::MAX_ENTRIES)) begin
						out_res.status <= mftf_pkg::ST_NO_MATCH;
						state_q <= S_DONE;
					end else if (hit) begin
						out_res.status <= mftf_pkg::ST_OK;
						out_res.entry_index <= f;
						out_res.matched_socket <= sock_q[f];
						state_q <= S_DONE;
					end else begin
						cur_q <= nxt_q[f];
						steps_q <= steps_q + mftf_pkg::CNT_W'(1);
					end
				end
				S_DONE: begin
					// raise valid, drop it once the result is taken
					out_valid <= !(out_valid && !out_stall);
					if (out_valid && !out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/masked_five_tuple_filter_table_unit.sv @@
// Top level of the masked five-tuple filter table.
// Add, set-mask, remove: the result is registered, then flagged valid; check: a walk of
// the priority list first, one entry compared per cycle. One command in the table at a
// time, so a new one starts once the last result is taken; a 2-entry queue
// takes transfers meanwhile. arst_n clears lists, valid bits and counters, not keys/masks.
// Depends on mftf_pkg, mftf_front, mftf_back.
module masked_five_tuple_filter_table_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] mode,
	input logic [2:0] entry,
	input logic [31:0] src_ip,
	input logic [15:0] sport,
	input logic [31:0] dst_ip,
	input logic [15:0] dport,
	input logic [7:0] protocol,
	input logic [15:0] socket_id,
	input logic [31:0] sip_mask,
	input logic [15:0] sport_mask,
	input logic [31:0] dip_mask,
	input logic [15:0] dport_mask,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [2:0] entry_index,
	output logic [15:0] matched_socket,
	output logic [3:0] used_count
);
	mftf_pkg::cmd_t in_cmd, q_cmd;
	mftf_pkg::res_t res;
	logic q_valid, q_pop;

	assign in_cmd = '{mode: mode, entry: entry, src_ip: src_ip, sport: sport,
		dst_ip: dst_ip, dport: dport, protocol: protocol, socket_id: socket_id,
		sip_mask: sip_mask, sport_mask: sport_mask,
		dip_mask: dip_mask, dport_mask: dport_mask};

	mftf_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_cmd,
		.q_valid, .q_pop, .q_cmd);
	mftf_back u_back (.clk, .arst_n, .q_valid, .q_pop, .q_cmd,
		.out_valid, .out_stall, .out_res(res));

	assign status = res.status;
	assign entry_index = res.entry_index;
	assign matched_socket = res.matched_socket;
	assign used_count = res.used_count;
endmodule

@@ rtl/core/mftf_checker.sv @@
// Port-level checks for the filter table top level, bound to it.
// Depends on mftf_pkg and masked_five_tuple_filter_table_unit.
module mftf_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] status,
	input logic [15:0] matched_socket,
	input logic [3:0] used_count
);
	// valid and status hold while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)) else $error("hold");
	// only a successful result can carry a socket
	a_sock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mftf_pkg::ST_OK |-> matched_socket == 16'd0)
		else $error("socket");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_count <= mftf_pkg::CNT_W'(mftf_pkg::MAX_ENTRIES))
		else $error("count");
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= mftf_pkg::ST_UNUSED) else $error("status");
endmodule

bind masked_five_tuple_filter_table_unit mftf_checker u_mftf_checker (.clk, .arst_n,
	.out_valid, .out_stall, .status, .matched_socket, .used_count);
